/* sv/ssmd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ssmd_pkg: shared types and constants
// Widths, codes and state encoding for the sparse map diff block.
// ----------------------------------------------------------------------------
package ssmd_pkg;

	localparam int MAX_CELLS_DEF  = 32;
	localparam int INDEX_BITS_DEF = 32;
	localparam int IDX_W          = 32;
	localparam int REV_W          = 32;
	localparam int OPS_W          = 7;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 32;

	localparam logic [OPS_W-1:0] MAX_OPS_RST = 7'd64;
	localparam logic [REV_W-1:0] SPAN_RST    = 32'd16;

	typedef enum logic [1:0] {
		OPC_LOAD_BASE   = 2'd0,
		OPC_LOAD_TARGET = 2'd1,
		OPC_RUN         = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		KIND_FREE   = 2'd0,
		KIND_OCC    = 2'd1,
		KIND_REMOVE = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_OP       = 3'd0,
		ST_NOCHANGE = 3'd1,
		ST_REVERR   = 3'd2,
		ST_LIMIT    = 3'd3,
		ST_OVERFLOW = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_OPS = 2'd0,
		REG_SPAN    = 2'd1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_COUNT,
		S_EMIT,
		S_REPORT
	} state_t;

endpackage
`default_nettype wire

/* sv/ssmd_item_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ssmd_item_if: input item channel
// Load and run words with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ssmd_item_if;
	import ssmd_pkg::*;

	logic              valid;
	logic              ready;
	logic [1:0]        opcode;
	logic [IDX_W-1:0]  cell_index;
	logic              cell_free;
	logic [REV_W-1:0]  base_revision;
	logic [REV_W-1:0]  target_revision;

	modport source (output valid, opcode, cell_index, cell_free, base_revision,
		target_revision, input ready);
	modport sink (input valid, opcode, cell_index, cell_free, base_revision,
		target_revision, output ready);
endinterface
`default_nettype wire

/* sv/ssmd_result_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ssmd_result_if: result channel
// Delta operation or status words with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ssmd_result_if;
	import ssmd_pkg::*;

	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] op_cell_index;
	logic [1:0]       op_kind;
	logic [2:0]       status;
	logic             last;

	modport source (output valid, op_cell_index, op_kind, status, last, input ready);
	modport sink (input valid, op_cell_index, op_kind, status, last, output ready);
endinterface
`default_nettype wire

/* sv/ssmd_cfg_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ssmd_cfg_if: configuration write channel
// Register index and write data with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ssmd_cfg_if;
	import ssmd_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* sv/ssmd_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ssmd_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ssmd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

/* sv/ssmd_list.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ssmd_list: one sorted cell list
// Append-only cell store with fill count; read at the walk pointer.
// ----------------------------------------------------------------------------
module ssmd_list import ssmd_pkg::*; #(
	parameter int MAX_CELLS = MAX_CELLS_DEF,
	parameter int STORE_W   = IDX_W,
	localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1,
	localparam int PW = $clog2(MAX_CELLS + 1)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire logic               clear,
	input  wire logic [STORE_W-1:0] wr_index,
	input  wire logic               wr_free,
	input  wire logic [PW-1:0]      rd_ptr,
	output logic      [STORE_W-1:0] rd_index,
	output logic                    rd_free,
	output logic      [PW-1:0]      count,
	output logic                    full
);

	logic [PW-1:0]    count_q;
	logic             we;
	logic [STORE_W:0] rdata;

	assign full  = (count_q == PW'(MAX_CELLS));
	assign we    = push && !full;
	assign count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (clear) begin
			count_q <= '0;
		end else if (we) begin
			count_q <= count_q + PW'(1);
		end
	end

	ssmd_ram #(
		.WIDTH (STORE_W + 1),
		.DEPTH (MAX_CELLS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (count_q[AW-1:0]),
		.wdata ({wr_free, wr_index}),
		.raddr (rd_ptr[AW-1:0]),
		.rdata (rdata)
	);

	assign rd_index = rdata[STORE_W-1:0];
	assign rd_free  = rdata[STORE_W];

endmodule
`default_nettype wire

/* sv/sorted_sparse_map_diff.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_sparse_map_diff: delta between two sorted sparse cell lists
// Loads base and target lists, then merges them into delta operations.
// ----------------------------------------------------------------------------
//  channel | dir | word
//  req     | in  | opcode, cell_index, cell_free, base_revision, target_revision
//  rsp     | out | op_cell_index, op_kind, status, last
//  cfg     | in  | index, data (always ready)
//
//  A run does a revision and overflow check, then one merge step per cycle in
//  a count walk (up to base+target entries, plus a closing step) and, if it
//  found operations and fits the limit, a second emit walk up to the last
//  operation; one shared compare unit does every step. req is not ready from
//  run accept until its last word is loaded. rsp stalls hold the emit walk.
//  No clearing pass after reset.
// ----------------------------------------------------------------------------
module sorted_sparse_map_diff import ssmd_pkg::*; #(
	parameter int MAX_CELLS  = MAX_CELLS_DEF,
	parameter int INDEX_BITS = INDEX_BITS_DEF
) (
	input wire logic      clk,
	input wire logic      arst_n,
	ssmd_item_if.sink     req,
	ssmd_result_if.source rsp,
	ssmd_cfg_if.sink      cfg
);

	localparam int STORE_W = (INDEX_BITS < IDX_W) ? INDEX_BITS : IDX_W;
	localparam int PW      = $clog2(MAX_CELLS + 1);

	state_t state_q, state_d;

	logic [OPS_W-1:0]   max_ops_q;
	logic [REV_W-1:0]   span_q;
	logic               ovf_q;
	logic [REV_W-1:0]   brev_q, trev_q;
	logic [PW-1:0]      bi_q, ti_q, bi_d, ti_d;
	logic [OPS_W-1:0]   n_q, n_d, e_q, e_d;
	status_t            err_q, err_d;

	logic               rsp_valid_q;
	logic [IDX_W-1:0]   rsp_idx_q;
	kind_t              rsp_kind_q;
	status_t            rsp_status_q;
	logic               rsp_last_q;

	logic               rsp_load;
	logic [IDX_W-1:0]   ld_idx;
	kind_t              ld_kind;
	status_t            ld_status;
	logic               slot_free;
	logic               list_clear;

	logic               accept;
	logic               push_b, push_t;
	logic [STORE_W-1:0] b_idx, t_idx;
	logic               b_free, t_free, b_full, t_full;
	logic [PW-1:0]      b_cnt, t_cnt;

	logic               b_more, t_more, any_more, b_lt, t_lt;
	logic               take_b, take_t, adv_b, adv_t, step_prod;
	logic [REV_W:0]     rev_diff;
	logic               rev_bad;

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_ops_q <= MAX_OPS_RST;
			span_q    <= SPAN_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_MAX_OPS: max_ops_q <= cfg.data[OPS_W-1:0];
				REG_SPAN:    span_q    <= cfg.data[REV_W-1:0];
				default: ;
			endcase
		end
	end

	// lists
	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign push_b    = accept && (req.opcode == OPC_LOAD_BASE);
	assign push_t    = accept && (req.opcode == OPC_LOAD_TARGET);

	ssmd_list #(.MAX_CELLS(MAX_CELLS), .STORE_W(STORE_W)) u_base (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push_b),
		.clear    (list_clear),
		.wr_index (req.cell_index[STORE_W-1:0]),
		.wr_free  (req.cell_free),
		.rd_ptr   (bi_d),
		.rd_index (b_idx),
		.rd_free  (b_free),
		.count    (b_cnt),
		.full     (b_full)
	);

	ssmd_list #(.MAX_CELLS(MAX_CELLS), .STORE_W(STORE_W)) u_target (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push_t),
		.clear    (list_clear),
		.wr_index (req.cell_index[STORE_W-1:0]),
		.wr_free  (req.cell_free),
		.rd_ptr   (ti_d),
		.rd_index (t_idx),
		.rd_free  (t_free),
		.count    (t_cnt),
		.full     (t_full)
	);

	// shared merge step
	assign b_more    = (bi_q < b_cnt);
	assign t_more    = (ti_q < t_cnt);
	assign any_more  = b_more || t_more;
	assign b_lt      = (b_idx < t_idx);
	assign t_lt      = (t_idx < b_idx);
	assign take_b    = b_more && (!t_more || b_lt);
	assign take_t    = t_more && (!b_more || t_lt);
	assign adv_b     = b_more && !take_t;
	assign adv_t     = t_more && !take_b;
	assign step_prod = take_b || take_t || (b_more && t_more && (b_free != t_free));

	// revision check
	assign rev_diff = {1'b0, trev_q} - {1'b0, brev_q};
	assign rev_bad  = rev_diff[REV_W] || (rev_diff[REV_W-1:0] == '0) ||
		(rev_diff[REV_W-1:0] > span_q);

	assign slot_free = !rsp_valid_q || rsp.ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && (req.opcode == OPC_RUN)) state_d = S_CHECK;
			end
			S_CHECK: begin
				state_d = (rev_bad || ovf_q) ? S_REPORT : S_COUNT;
			end
			S_COUNT: begin
				if (!any_more) begin
					state_d = (n_q == '0) ? S_REPORT : S_EMIT;
				end else if (n_q == max_ops_q) begin
					state_d = S_REPORT;
				end
			end
			S_EMIT: begin
				if (slot_free && step_prod && (e_q + OPS_W'(1) == n_q)) state_d = S_IDLE;
			end
			S_REPORT: begin
				if (slot_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		bi_d       = bi_q;
		ti_d       = ti_q;
		n_d        = n_q;
		e_d        = e_q;
		err_d      = err_q;
		rsp_load   = 1'b0;
		ld_idx     = IDX_W'(take_b ? b_idx : t_idx);
		ld_kind    = take_b ? KIND_REMOVE : (t_free ? KIND_FREE : KIND_OCC);
		ld_status  = ST_OP;
		list_clear = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				bi_d = '0;
				ti_d = '0;
			end
			S_CHECK: begin
				n_d = '0;
				if (rev_bad) begin
					err_d = ST_REVERR;
				end else if (ovf_q) begin
					err_d = ST_OVERFLOW;
				end
			end
			S_COUNT: begin
				if (!any_more) begin
					bi_d  = '0;
					ti_d  = '0;
					e_d   = '0;
					err_d = ST_NOCHANGE;
				end else if (n_q == max_ops_q) begin
					err_d = ST_LIMIT;
				end else begin
					if (adv_b) bi_d = bi_q + PW'(1);
					if (adv_t) ti_d = ti_q + PW'(1);
					if (step_prod) n_d = n_q + OPS_W'(1);
				end
			end
			S_EMIT: begin
				if (slot_free) begin
					if (adv_b) bi_d = bi_q + PW'(1);
					if (adv_t) ti_d = ti_q + PW'(1);
					if (step_prod) begin
						rsp_load = 1'b1;
						e_d      = e_q + OPS_W'(1);
						if (e_q + OPS_W'(1) == n_q) list_clear = 1'b1;
					end
				end
			end
			S_REPORT: begin
				if (slot_free) begin
					rsp_load   = 1'b1;
					ld_idx     = '0;
					ld_kind    = KIND_FREE;
					ld_status  = err_q;
					list_clear = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			bi_q        <= '0;
			ti_q        <= '0;
			n_q         <= '0;
			e_q         <= '0;
			err_q       <= ST_OP;
			ovf_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			bi_q    <= bi_d;
			ti_q    <= ti_d;
			n_q     <= n_d;
			e_q     <= e_d;
			err_q   <= err_d;
			if (list_clear) begin
				ovf_q <= 1'b0;
			end else if ((push_b && b_full) || (push_t && t_full)) begin
				ovf_q <= 1'b1;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (req.opcode == OPC_RUN)) begin
			brev_q <= req.base_revision;
			trev_q <= req.target_revision;
		end
		if (rsp_load) begin
			rsp_idx_q    <= ld_idx;
			rsp_kind_q   <= ld_kind;
			rsp_status_q <= ld_status;
			rsp_last_q   <= list_clear;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.op_cell_index = rsp_idx_q;
	assign rsp.op_kind       = rsp_kind_q;
	assign rsp.status        = rsp_status_q;
	assign rsp.last          = rsp_last_q;

endmodule
`default_nettype wire

/* tb/sv/sorted_sparse_map_diff_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_sparse_map_diff_tb: self-checking bench for the sparse map diff
// Loads base and target cell lists, runs diffs and checks each delta word
// against a predictor of the merge, under random input gaps and output stalls.
// ----------------------------------------------------------------------------
module sorted_sparse_map_diff_tb;
	import ssmd_pkg::*;

	localparam logic [1:0]           OPC_NONE     = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
	localparam int                   RUN_WORDS    = 340;
	localparam int                   PHASE_WORDS  = 45;

	typedef struct {
		logic [1:0]       opcode;
		logic [IDX_W-1:0] cell_index;
		logic             cell_free;
		logic [REV_W-1:0] base_rev;
		logic [REV_W-1:0] target_rev;
	} map_word_t;

	typedef struct {
		logic [IDX_W-1:0] cell_idx;
		kind_t            kind;
		status_t          status;
		logic             last;
	} delta_word_t;

	typedef enum {RX_OPEN, RX_CHOPPY, RX_CHOKED} rx_mode_t;
	typedef enum {SEQ_TYPICAL, SEQ_FULL, SEQ_OVERFLOW, SEQ_UNORDERED, SEQ_BAD_REV} seq_shape_t;

	class delta_scoreboard;
		logic [IDX_W-1:0] base_idx[MAX_CELLS_DEF];
		logic             base_free[MAX_CELLS_DEF];
		logic [IDX_W-1:0] target_idx[MAX_CELLS_DEF];
		logic             target_free[MAX_CELLS_DEF];
		int               base_n;
		int               target_n;
		bit               overflow;
		logic [OPS_W-1:0] op_limit;
		logic [REV_W-1:0] rev_span;
		delta_word_t      expected_deltas[$];
		int               mismatches;

		function new();
			base_n = 0;
			target_n = 0;
			overflow = 0;
			op_limit = MAX_OPS_RST;
			rev_span = SPAN_RST;
			mismatches = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_MAX_OPS)
				op_limit = data[OPS_W-1:0];
			else if (idx == REG_SPAN)
				rev_span = data[REV_W-1:0];
		endfunction

		function delta_word_t delta(logic [IDX_W-1:0] idx, kind_t kind, status_t st,
			logic last);
			delta_word_t d;
			d.cell_idx = idx;
			d.kind = kind;
			d.status = st;
			d.last = last;
			return d;
		endfunction

		function kind_t kind_for(logic free);
			return free ? KIND_FREE : KIND_OCC;
		endfunction

		function void note_item(map_word_t w);
			delta_word_t      ops[$];
			status_t          err;
			logic [REV_W-1:0] step;
			int               bi;
			int               ti;
			bi = 0;
			ti = 0;
			err = ST_OP;
			case (w.opcode)
			OPC_LOAD_BASE: begin
				if (base_n >= MAX_CELLS_DEF) begin
					overflow = 1;
				end else begin
					base_idx[base_n] = w.cell_index;
					base_free[base_n] = w.cell_free;
					base_n++;
				end
			end
			OPC_LOAD_TARGET: begin
				if (target_n >= MAX_CELLS_DEF) begin
					overflow = 1;
				end else begin
					target_idx[target_n] = w.cell_index;
					target_free[target_n] = w.cell_free;
					target_n++;
				end
			end
			OPC_RUN: begin
				step = w.target_rev - w.base_rev;
				if (w.target_rev <= w.base_rev || step > rev_span)
					err = ST_REVERR;
				else if (overflow)
					err = ST_OVERFLOW;
				while (err == ST_OP && (bi < base_n || ti < target_n)) begin
					if (ops.size() == op_limit) begin
						err = ST_LIMIT;
						break;
					end
					if (bi == base_n || (ti < target_n && target_idx[ti] < base_idx[bi])) begin
						ops.insert(ops.size(),
							delta(target_idx[ti], kind_for(target_free[ti]), ST_OP, 0));
						ti++;
					end else if (ti == target_n || base_idx[bi] < target_idx[ti]) begin
						ops.insert(ops.size(), delta(base_idx[bi], KIND_REMOVE, ST_OP, 0));
						bi++;
					end else begin
						if (base_free[bi] != target_free[ti])
							ops.insert(ops.size(),
								delta(target_idx[ti], kind_for(target_free[ti]), ST_OP, 0));
						bi++;
						ti++;
					end
				end
				base_n = 0;
				target_n = 0;
				overflow = 0;
				if (err != ST_OP) begin
					expected_deltas.insert(expected_deltas.size(),
						delta('0, KIND_FREE, err, 1));
				end else if (ops.size() == 0) begin
					expected_deltas.insert(expected_deltas.size(),
						delta('0, KIND_FREE, ST_NOCHANGE, 1));
				end else begin
					ops[ops.size()-1].last = 1;
					foreach (ops[k])
						expected_deltas.insert(expected_deltas.size(), ops[k]);
				end
			end
			default: ;
			endcase
		endfunction

		function void check_delta(delta_word_t got);
			delta_word_t want;
			if (expected_deltas.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected word cell=%h kind=%0d status=%0d last=%0d",
					$time, got.cell_idx, got.kind, got.status, got.last);
				return;
			end
			want = expected_deltas.pop_front();
			if (got.cell_idx !== want.cell_idx || got.kind !== want.kind ||
				got.status !== want.status || got.last !== want.last) begin
				mismatches++;
				$display("%0t: mismatch expected cell=%h kind=%0d status=%0d last=%0d",
					$time, want.cell_idx, want.kind, want.status, want.last);
				$display("%0t:          actual   cell=%h kind=%0d status=%0d last=%0d",
					$time, got.cell_idx, got.kind, got.status, got.last);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	ssmd_item_if   req_if();
	ssmd_result_if rsp_if();
	ssmd_cfg_if    cfg_if();

	sorted_sparse_map_diff i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if),
		.cfg    (cfg_if)
	);

	delta_scoreboard sb;
	int              burst_left;
	int              words_sent;
	rx_mode_t        rx_mode;
	int              rx_left;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// result sink stall pattern
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 2));
			rx_left = $urandom_range(16, 160);
		end
		rx_left--;
		case (rx_mode)
		RX_OPEN:   rsp_if.ready <= 1'b1;
		RX_CHOPPY: rsp_if.ready <= 1'($urandom_range(0, 1));
		default:   rsp_if.ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	always @(posedge clk) begin
		delta_word_t seen;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			seen.cell_idx = rsp_if.op_cell_index;
			seen.kind = kind_t'(rsp_if.op_kind);
			seen.status = status_t'(rsp_if.status);
			seen.last = rsp_if.last;
			sb.check_delta(seen);
		end
	end

	task automatic send_word(map_word_t w);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				req_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_if.valid <= 1'b1;
		req_if.opcode <= w.opcode;
		req_if.cell_index <= w.cell_index;
		req_if.cell_free <= w.cell_free;
		req_if.base_revision <= w.base_rev;
		req_if.target_revision <= w.target_rev;
		do @(posedge clk); while (!req_if.ready);
		sb.note_item(w);
		if (w.opcode != OPC_NONE)
			words_sent++;
	endtask

	task automatic load_cell(logic to_target, logic [IDX_W-1:0] idx, logic free);
		map_word_t w;
		w.opcode = to_target ? OPC_LOAD_TARGET : OPC_LOAD_BASE;
		w.cell_index = idx;
		w.cell_free = free;
		w.base_rev = $urandom;
		w.target_rev = $urandom;
		send_word(w);
	endtask

	task automatic run_diff(logic [REV_W-1:0] brev, logic [REV_W-1:0] trev);
		map_word_t w;
		w.opcode = OPC_RUN;
		w.cell_index = $urandom;
		w.cell_free = 1'($urandom_range(0, 1));
		w.base_rev = brev;
		w.target_rev = trev;
		send_word(w);
	endtask

	task automatic stray_word();
		map_word_t w;
		w.opcode = OPC_NONE;
		w.cell_index = $urandom;
		w.cell_free = 1'($urandom_range(0, 1));
		w.base_rev = $urandom;
		w.target_rev = $urandom;
		send_word(w);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= data;
		do @(posedge clk); while (!cfg_if.ready);
		sb.write_reg(idx, data);
		cfg_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic settle();
		req_if.valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (sb.expected_deltas.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic run_with_revs(bit in_span);
		logic [REV_W-1:0] step;
		logic [REV_W-1:0] brev;
		logic [REV_W-1:0] trev;
		logic [REV_W-1:0] span;
		span = sb.rev_span;
		if (in_span) begin
			case ($urandom_range(0, 3))
			0:       step = span;
			1:       step = 1;
			default: step = $urandom_range(1, span);
			endcase
			brev = $urandom_range(0, 32'hFFFF_FFFF - step);
			trev = brev + step;
		end else begin
			brev = $urandom;
			case ($urandom_range(0, 2))
			0: trev = brev;
			1: trev = $urandom_range(0, brev);
			default: begin
				step = span + $urandom_range(1, 3);
				brev = $urandom_range(0, 32'hFFFF_FFFF - step);
				trev = brev + step;
			end
			endcase
		end
		run_diff(brev, trev);
	endtask

	task automatic diff_sequence(seq_shape_t shape);
		logic [IDX_W-1:0] bq[$];
		logic [IDX_W-1:0] tq[$];
		logic             bfq[$];
		logic             tfq[$];
		longint           cur;
		longint           stride;
		int               pool;
		int               fat;
		logic             free;
		bit               pick_t;
		case (shape)
		SEQ_FULL: begin
			cur = longint'($urandom_range(0, 1000));
			for (int k = 0; k < 2 * MAX_CELLS_DEF; k++) begin
				if (k % 2 == 0) begin
					bq.insert(bq.size(), cur[31:0]);
					bfq.insert(bfq.size(), 1'($urandom_range(0, 1)));
				end else begin
					tq.insert(tq.size(), cur[31:0]);
					tfq.insert(tfq.size(), 1'($urandom_range(0, 1)));
				end
				cur += longint'($urandom_range(1, 3));
			end
		end
		SEQ_UNORDERED: begin
			repeat ($urandom_range(2, 8)) begin
				if ($urandom_range(0, 1)) begin
					bq.insert(bq.size(), $urandom);
					bfq.insert(bfq.size(), 1'($urandom_range(0, 1)));
				end else begin
					tq.insert(tq.size(), $urandom);
					tfq.insert(tfq.size(), 1'($urandom_range(0, 1)));
				end
			end
		end
		SEQ_OVERFLOW: begin
			fat = MAX_CELLS_DEF + $urandom_range(1, 3);
			cur = longint'($urandom_range(0, 32'h7FFF_FFFF));
			pick_t = 1'($urandom_range(0, 1));
			for (int k = 0; k < fat; k++) begin
				if (pick_t) begin
					tq.insert(tq.size(), cur[31:0]);
					tfq.insert(tfq.size(), 1'($urandom_range(0, 1)));
				end else begin
					bq.insert(bq.size(), cur[31:0]);
					bfq.insert(bfq.size(), 1'($urandom_range(0, 1)));
				end
				cur += longint'($urandom_range(1, 1000));
			end
			repeat ($urandom_range(0, 3)) begin
				if (pick_t) begin
					bq.insert(bq.size(), $urandom);
					bfq.insert(bfq.size(), 1'($urandom_range(0, 1)));
				end else begin
					tq.insert(tq.size(), $urandom);
					tfq.insert(tfq.size(), 1'($urandom_range(0, 1)));
				end
			end
		end
		default: begin
			pool = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 6);
			stride = $urandom_range(0, 1) ? longint'($urandom_range(1, 4)) :
				longint'($urandom_range(1, 32'h0800_0000));
			case ($urandom_range(0, 2))
			0: cur = 0;
			1: cur = longint'($urandom);
			default: cur = 64'h1_0000_0000 - pool * stride;
			endcase
			if (cur < 0)
				cur = 0;
			repeat (pool) begin
				if (cur > 64'hFFFF_FFFF)
					break;
				free = 1'($urandom_range(0, 1));
				case ($urandom_range(0, 3))
				0: begin
					if (bq.size() < MAX_CELLS_DEF) begin
						bq.insert(bq.size(), cur[31:0]);
						bfq.insert(bfq.size(), free);
					end
				end
				1: begin
					if (tq.size() < MAX_CELLS_DEF) begin
						tq.insert(tq.size(), cur[31:0]);
						tfq.insert(tfq.size(), free);
					end
				end
				default: begin
					if (bq.size() < MAX_CELLS_DEF && tq.size() < MAX_CELLS_DEF) begin
						bq.insert(bq.size(), cur[31:0]);
						bfq.insert(bfq.size(), free);
						tq.insert(tq.size(), cur[31:0]);
						tfq.insert(tfq.size(), $urandom_range(0, 1) ? free : !free);
					end
				end
				endcase
				cur += longint'($urandom_range(1, 32'(stride)));
			end
		end
		endcase
		// interleave the two lists at random
		while (bq.size() != 0 || tq.size() != 0) begin
			if ($urandom_range(0, 39) == 0)
				stray_word();
			if (bq.size() == 0)
				pick_t = 1;
			else if (tq.size() == 0)
				pick_t = 0;
			else
				pick_t = 1'($urandom_range(0, 1));
			if (pick_t)
				load_cell(1'b1, tq.pop_front(), tfq.pop_front());
			else
				load_cell(1'b0, bq.pop_front(), bfq.pop_front());
		end
		run_with_revs(shape != SEQ_BAD_REV && $urandom_range(0, 15) != 0);
	endtask

	initial begin
		int         phase;
		int         seq_n;
		int         phase_end;
		int         r;
		seq_shape_t shape;
		sb = new();
		burst_left = 0;
		words_sent = 0;
		rx_left = 0;
		rx_mode = RX_OPEN;
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.opcode = OPC_LOAD_BASE;
		req_if.cell_index = '0;
		req_if.cell_free = 1'b0;
		req_if.base_revision = '0;
		req_if.target_revision = '0;
		rsp_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = REG_MAX_OPS;
		cfg_if.data = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset limits: 64 ops, span 16
		run_diff(32'd0, 32'd1);
		load_cell(1'b0, 32'd0, 1'b1);
		load_cell(1'b0, 32'hFFFF_FFFF, 1'b0);
		load_cell(1'b1, 32'd0, 1'b0);
		stray_word();
		load_cell(1'b1, 32'd5, 1'b1);
		run_diff(32'd100, 32'd116);
		load_cell(1'b0, 32'd7, 1'b1);
		load_cell(1'b1, 32'd7, 1'b1);
		run_diff(32'd5, 32'd6);
		load_cell(1'b0, 32'd1, 1'b0);
		run_diff(32'd10, 32'd10);
		run_diff(32'd20, 32'd3);
		run_diff(32'd0, 32'd17);
		run_diff(32'hFFFF_FFFF, 32'd0);
		// unsorted base list
		load_cell(1'b0, 32'd9, 1'b0);
		load_cell(1'b0, 32'd3, 1'b1);
		load_cell(1'b1, 32'd5, 1'b0);
		run_diff(32'hFFFF_FFF0, 32'hFFFF_FFFF);
		settle();

		write_reg(REG_MAX_OPS, 32'd0);
		run_diff(32'd1, 32'd2);
		load_cell(1'b1, 32'd1, 1'b1);
		run_diff(32'd1, 32'd2);
		settle();

		// limit hit while the remaining pair is unchanged
		write_reg(REG_MAX_OPS, 32'd1);
		load_cell(1'b0, 32'd1, 1'b1);
		load_cell(1'b0, 32'd2, 1'b1);
		load_cell(1'b1, 32'd1, 1'b0);
		load_cell(1'b1, 32'd2, 1'b1);
		run_diff(32'd7, 32'd8);
		load_cell(1'b0, 32'd8, 1'b1);
		run_diff(32'd7, 32'd8);
		settle();

		phase = 0;
		seq_n = 0;
		while (words_sent < RUN_WORDS) begin
			case (phase % 6)
			0: begin
				write_reg(REG_MAX_OPS, 32'd64);
				write_reg(REG_SPAN, 32'hFFFF_FFFF);
			end
			1: begin
				write_reg(REG_MAX_OPS, $urandom_range(1, 8));
				write_reg(REG_SPAN, 32'd1);
			end
			2: begin
				write_reg(REG_MAX_OPS, 32'd0);
				write_reg(REG_SPAN, $urandom_range(1, 100));
			end
			3: begin
				write_reg(REG_MAX_OPS, $urandom_range(0, 64));
				write_reg(REG_SPAN, $urandom_range(1, 32'hFFFF_FFFF));
			end
			4: begin
				write_reg(REG_MAX_OPS, 32'd64);
				write_reg(REG_SPAN, $urandom_range(2, 64));
				write_reg(REG_UNMAPPED, $urandom);
			end
			default: begin
				write_reg(REG_MAX_OPS, $urandom_range(32, 64));
				write_reg(REG_SPAN, $urandom_range(16, 4096));
			end
			endcase
			phase_end = words_sent + PHASE_WORDS;
			while (words_sent < phase_end && words_sent < RUN_WORDS) begin
				r = $urandom_range(0, 19);
				if (seq_n == 0 || r == 0)
					shape = SEQ_OVERFLOW;
				else if (seq_n == 1 || r == 1)
					shape = SEQ_FULL;
				else if (r < 4)
					shape = SEQ_UNORDERED;
				else if (r == 4)
					shape = SEQ_BAD_REV;
				else
					shape = SEQ_TYPICAL;
				diff_sequence(shape);
				seq_n++;
			end
			settle();
			phase++;
		end

		settle();
		if (sb.mismatches == 0 && sb.expected_deltas.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
